/* design/ssr_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package ssr_pkg;

    // counts of one segment of results, up to the largest pattern or replacement
    localparam int CNT_W = 4;
    // total results of one transfer
    localparam int TOT_W = 5;

    typedef struct packed {
        logic [CNT_W-1:0] a;
        logic [CNT_W-1:0] r;
        logic             e;
        logic [CNT_W-1:0] c;
        logic [TOT_W-1:0] tot;
        logic             marker;
        logic             last;
        logic [7:0]       b;
    } t_desc;

    typedef struct packed {
        logic [7:0] data;
        logic       bvalid;
        logic       last;
    } t_ent;

    typedef struct packed {
        logic keep;
        logic load;
        logic pop;
    } t_cell_ctl;

endpackage

`default_nettype wire

/* design/stream_search_replace_top.sv */
`timescale 1ns / 1ps
`default_nettype none

// channel   direction  handshake           payload
// input     in         i_valid / o_stall   i_in_byte, i_in_last
// output    out        o_valid / i_stall   o_out_byte, o_byte_valid, o_out_last
// config    in         i_cfg_we            i_cfg_index, i_cfg_data
//
// one byte is taken per cycle while each byte gives at most one result and no
// output stall comes; a byte that gives n > 1 results holds the input: the
// output cell row delivers one result per cycle when the output is not stalled
// and takes a new byte once at most one result is left in it
// an output stall holds the input while the row holds two or more results
// synchronous reset clears the match count, the cell row count and the config registers

module stream_search_replace_top import ssr_pkg::*; #(
    parameter int MAX_PATTERN = 8,
    parameter int MAX_REPLACE = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_in_byte,
    input  logic        i_in_last,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [7:0]  o_out_byte,
    output logic        o_byte_valid,
    output logic        o_out_last,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data
);

    localparam int PIW   = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
    localparam int RD    = (MAX_REPLACE > 0) ? MAX_REPLACE : 1;
    localparam int NCELL = 2 * MAX_PATTERN + MAX_REPLACE + 1;
    localparam int CW    = $clog2(NCELL + 1);

    localparam logic [1:0] CFG_PAT_BYTES = 2'd0;
    localparam logic [1:0] CFG_PAT_LEN   = 2'd1;
    localparam logic [1:0] CFG_REP_BYTES = 2'd2;
    localparam logic [1:0] CFG_REP_LEN   = 2'd3;

    logic [MAX_PATTERN-1:0][7:0] r_pat;
    logic [RD-1:0][7:0]          r_rep;
    logic [CNT_W-1:0]            r_plen;
    logic [CNT_W-1:0]            r_rlen;
    logic [CNT_W-1:0]            w_plen;
    logic [CNT_W-1:0]            w_rlen;
    logic [PIW-1:0]              r_m;
    logic [PIW-1:0]              n_m;
    logic [CW-1:0]               r_cnt;
    logic [CW-1:0]               n_cnt;
    logic [CW-1:0]               w_rem;
    logic                        w_pop;
    logic                        w_acc;
    t_desc                       w_desc;
    t_ent                        w_ent [NCELL];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat  <= '0;
            r_rep  <= '0;
            r_plen <= '0;
            r_rlen <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_PAT_BYTES: r_pat  <= i_cfg_data[8*MAX_PATTERN-1:0];
                CFG_PAT_LEN:   r_plen <= i_cfg_data[CNT_W-1:0];
                CFG_REP_BYTES: r_rep  <= i_cfg_data[8*RD-1:0];
                CFG_REP_LEN:   r_rlen <= i_cfg_data[CNT_W-1:0];
            endcase
        end
    end

    assign w_plen = (r_plen > CNT_W'(MAX_PATTERN)) ? CNT_W'(MAX_PATTERN) : r_plen;
    assign w_rlen = (r_rlen > CNT_W'(MAX_REPLACE)) ? CNT_W'(MAX_REPLACE) : r_rlen;

    ssr_search #(
        .MAX_PATTERN(MAX_PATTERN)
    ) u_search (
        .i_pat  (r_pat),
        .i_plen (w_plen),
        .i_rlen (w_rlen),
        .i_m    (r_m),
        .i_byte (i_in_byte),
        .i_last (i_in_last),
        .o_desc (w_desc),
        .o_m    (n_m)
    );

    assign o_valid = (r_cnt != '0);
    assign w_pop   = o_valid && !i_stall;
    assign w_rem   = r_cnt - CW'(w_pop);
    assign o_stall = (w_rem > CW'(1));
    assign w_acc   = i_valid && !o_stall;
    assign n_cnt   = w_rem + (w_acc ? CW'(w_desc.tot) : CW'(0));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_m   <= '0;
        end else begin
            r_cnt <= n_cnt;
            if (w_acc) begin
                r_m <= n_m;
            end
        end
    end

    for (genvar j = 0; j < NCELL; j++) begin : g_cell
        t_cell_ctl        w_ctl;
        t_ent             w_nb;
        logic [TOT_W-1:0] w_q;

        assign w_ctl = '{keep: (CW'(j) < w_rem), load: w_acc, pop: w_pop};
        assign w_q   = TOT_W'(j) - TOT_W'(w_rem);

        if (j == NCELL - 1) begin : g_end
            assign w_nb = w_ent[j];
        end else begin : g_mid
            assign w_nb = w_ent[j+1];
        end

        ssr_cell #(
            .MAX_PATTERN(MAX_PATTERN),
            .MAX_REPLACE(MAX_REPLACE)
        ) u_cell (
            .i_clk  (i_clk),
            .i_ctl  (w_ctl),
            .i_next (w_nb),
            .i_q    (w_q),
            .i_desc (w_desc),
            .i_pat  (r_pat),
            .i_rep  (r_rep),
            .o_ent  (w_ent[j])
        );
    end

    assign o_out_byte   = w_ent[0].data;
    assign o_byte_valid = w_ent[0].bvalid;
    assign o_out_last   = w_ent[0].last;

endmodule

`default_nettype wire

/* design/ssr_search.sv */
`timescale 1ns / 1ps
`default_nettype none

module ssr_search import ssr_pkg::*; #(
    parameter int MAX_PATTERN = 8,
    localparam int PIW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1
) (
    input  logic [MAX_PATTERN-1:0][7:0] i_pat,
    input  logic [CNT_W-1:0]            i_plen,
    input  logic [CNT_W-1:0]            i_rlen,
    input  logic [PIW-1:0]              i_m,
    input  logic [7:0]                  i_byte,
    input  logic                        i_last,
    output t_desc                       o_desc,
    output logic [PIW-1:0]              o_m
);

    logic [CNT_W-1:0] w_m;
    logic [CNT_W-1:0] w_m1;
    logic [CNT_W-1:0] w_m2;
    logic [CNT_W-1:0] w_m3;
    logic [CNT_W-1:0] w_k;
    logic [CNT_W-1:0] w_idx;
    logic             w_stale;
    logic             w_hit;
    logic             w_ok;
    t_desc            w_d;

    // longest held suffix, extended by the new byte, that is a pattern prefix
    always_comb begin
        w_m     = CNT_W'(i_m);
        w_stale = (w_m != '0) && (w_m >= i_plen);
        w_m1    = w_stale ? '0 : w_m;
        w_hit   = (i_byte == i_pat[w_m1[PIW-1:0]]);
        w_k     = '0;
        w_idx   = '0;
        w_ok    = 1'b0;
        for (int kk = 1; kk < MAX_PATTERN; kk++) begin
            w_ok = (CNT_W'(kk) <= w_m1) && (i_byte == i_pat[kk-1]);
            for (int jj = 0; jj < kk - 1; jj++) begin
                w_idx = w_m1 + CNT_W'(1) - CNT_W'(kk) + CNT_W'(jj);
                w_ok  = w_ok && (i_pat[w_idx[PIW-1:0]] == i_pat[jj]);
            end
            if (w_ok) begin
                w_k = CNT_W'(kk);
            end
        end
    end

    always_comb begin
        w_d      = '0;
        w_d.b    = i_byte;
        w_d.last = i_last;
        w_m2     = w_m1 + CNT_W'(1);
        w_m3     = w_m1;
        if (w_stale) begin
            w_d.a = w_m;
        end
        if (i_plen == '0) begin
            w_d.e = 1'b1;
        end else if (w_hit) begin
            if (w_m2 >= i_plen) begin
                w_d.r = i_rlen;
                w_m3  = '0;
            end else begin
                w_m3 = w_m2;
            end
        end else begin
            if (w_k == '0) begin
                w_d.e = 1'b1;
                if (!w_stale) begin
                    w_d.a = w_m1;
                end
            end else begin
                w_d.a = w_m1 + CNT_W'(1) - w_k;
            end
            w_m3 = w_k;
        end
        if (i_last) begin
            w_d.c = w_m3;
            o_m   = '0;
        end else begin
            o_m   = w_m3[PIW-1:0];
        end
        w_d.tot = TOT_W'(w_d.a) + TOT_W'(w_d.r) + TOT_W'(w_d.e) + TOT_W'(w_d.c);
        if (i_last && (w_d.tot == '0)) begin
            w_d.marker = 1'b1;
            w_d.tot    = TOT_W'(1);
        end
        o_desc = w_d;
    end

endmodule

`default_nettype wire

/* design/ssr_cell.sv */
`timescale 1ns / 1ps
`default_nettype none

module ssr_cell import ssr_pkg::*; #(
    parameter int MAX_PATTERN = 8,
    parameter int MAX_REPLACE = 8,
    localparam int PIW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1,
    localparam int RD  = (MAX_REPLACE > 0) ? MAX_REPLACE : 1,
    localparam int RIW = (RD > 1) ? $clog2(RD) : 1
) (
    input  logic                        i_clk,
    input  t_cell_ctl                   i_ctl,
    input  t_ent                        i_next,
    input  logic [TOT_W-1:0]            i_q,
    input  t_desc                       i_desc,
    input  logic [MAX_PATTERN-1:0][7:0] i_pat,
    input  logic [RD-1:0][7:0]          i_rep,
    output t_ent                        o_ent
);

    t_ent             r_ent;
    t_ent             n_ent;
    t_ent             w_gen;
    logic [TOT_W-1:0] w_ar;
    logic [TOT_W-1:0] w_are;
    logic [TOT_W-1:0] w_qa;
    logic [TOT_W-1:0] w_qp;

    // result number i_q of the transfer being loaded
    always_comb begin
        w_ar         = TOT_W'(i_desc.a) + TOT_W'(i_desc.r);
        w_are        = w_ar + TOT_W'(i_desc.e);
        w_qa         = i_q - TOT_W'(i_desc.a);
        w_qp         = i_q - w_are;
        w_gen.bvalid = !i_desc.marker;
        w_gen.last   = i_desc.last && (i_q == (i_desc.tot - TOT_W'(1)));
        if (i_desc.marker) begin
            w_gen.data = 8'h00;
        end else if (i_q < TOT_W'(i_desc.a)) begin
            w_gen.data = i_pat[i_q[PIW-1:0]];
        end else if (i_q < w_ar) begin
            w_gen.data = i_rep[w_qa[RIW-1:0]];
        end else if (i_q < w_are) begin
            w_gen.data = i_desc.b;
        end else begin
            w_gen.data = i_pat[w_qp[PIW-1:0]];
        end
    end

    always_comb begin
        n_ent = r_ent;
        if (i_ctl.keep) begin
            if (i_ctl.pop) begin
                n_ent = i_next;
            end
        end else if (i_ctl.load) begin
            n_ent = w_gen;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ent <= n_ent;
    end

    assign o_ent = r_ent;

endmodule

`default_nettype wire

/* design/ssr_checker.sv */
`timescale 1ns / 1ps
`default_nettype none

module ssr_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_out_valid,
    input logic       i_out_stall,
    input logic       i_in_stall,
    input logic [7:0] i_out_byte,
    input logic       i_byte_valid,
    input logic       i_out_last
);

    // stalled result stays and holds its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_stall |=> i_out_valid && $stable(i_out_byte)
            && $stable(i_byte_valid) && $stable(i_out_last))
        else $error("stalled result changed");

    // a bare end marker closes the string
    a_marker_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_byte_valid |-> i_out_last)
        else $error("end marker without last");

    // a bare end marker carries a zero byte
    a_marker_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_byte_valid |-> (i_out_byte == 8'h00))
        else $error("end marker with data");

    // nothing pending means the input is open
    a_empty_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid |-> !i_in_stall)
        else $error("input stalled with no result pending");

endmodule

bind stream_search_replace_top ssr_checker u_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_out_valid  (o_valid),
    .i_out_stall  (i_stall),
    .i_in_stall   (o_stall),
    .i_out_byte   (o_out_byte),
    .i_byte_valid (o_byte_valid),
    .i_out_last   (o_out_last)
);

`default_nettype wire
